// ----- sv/pipt_pkg.sv -----
// Shared types and codes for the point-in-polygon test core.
package pipt_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEST   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Classification of one polygon edge against the tested point.
   typedef struct packed {
      logic straddle;   // ends lie on different sides of the point's row
      logic same_side;  // both ends strictly left or both strictly right of the point
      logic px_ge;      // current vertex x at or right of the point
      logic den_pos;    // previous vertex y above current vertex y
   } edge_flags_type;

   typedef struct packed {
      logic toggle;
      logic boundary;
   } edge_verdict_type;

endpackage

// ----- sv/pipt_vertex_ram.sv -----
// Vertex store: one write port, one read port with registered read data.
module pipt_vertex_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pipt_mul_unit.sv -----
// Shared signed multiplier with a registered product.
module pipt_mul_unit #(
   parameter int OPW = 17
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [OPW-1:0]   op_a,
   input  logic signed [OPW-1:0]   op_b,
   output logic signed [2*OPW-1:0] product
);

   logic signed [2*OPW-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= (2*OPW)'(op_a) * (2*OPW)'(op_b);
      end
   end

   assign product = product_ff;

endmodule

// ----- sv/pipt_edge_judge.sv -----
// Crossing decision for one classified edge from its two cross products.
module pipt_edge_judge #(
   parameter int PW = 34
) (
   input  pipt_pkg::edge_flags_type   flags,
   input  logic signed [PW-1:0]       num,
   input  logic signed [PW-1:0]       rhs,
   output pipt_pkg::edge_verdict_type verdict
);

   logic equal;
   logic crosses;

   // The intercept compare flips direction with the sign of the y span.
   assign equal   = (num == rhs);
   assign crosses = flags.den_pos ? (num <= rhs) : (num >= rhs);

   always_comb begin
      verdict.toggle   = 1'b0;
      verdict.boundary = 1'b0;
      if (flags.straddle) begin
         if (flags.same_side) begin
            verdict.toggle = flags.px_ge;
         end else begin
            verdict.boundary = equal;
            verdict.toggle   = !equal && crosses;
         end
      end
   end

endmodule

// ----- sv/point_in_polygon_test_core.sv -----
// Point-in-polygon test core: vertex store, edge-walk sequencer and result register.
// Clear, append and unused op words: busy stays low, result strobe in the next cycle.
// Test word on a non-empty store: busy during the walk, result strobe in the cycle after;
// each edge takes two passes through the single shared multiplier.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous reset empties the polygon and clears the sequencer; the store is not swept.
module point_in_polygon_test_core #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_op,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_strobe,
   output logic                         rsp_inside_res,
   output logic                         rsp_on_boundary,
   output logic [1:0]                   rsp_status
);

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int W   = COORD_BITS;
   localparam int OPW = COORD_BITS + 1;
   localparam int PW  = 2 * OPW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic signed [W-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic signed [W-1:0]        qx_ff, qx_in, qy_ff, qy_in;
   logic signed [W-1:0]        px_ff, px_in, py_ff, py_in;
   logic signed [PW-1:0]       num_ff, num_in;
   pipt_pkg::edge_flags_type   flags_ff, flags_in;
   logic                       parity_ff, parity_in;
   logic                       bound_ff, bound_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic                       rsp_inside_ff, rsp_inside_in;
   logic                       rsp_onb_ff, rsp_onb_in;
   pipt_pkg::status_type       rsp_status_ff, rsp_status_in;

   logic                       accept;
   logic                       imm_accept;
   pipt_pkg::op_type           op;
   logic                       wr_en;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [2*W-1:0]             rd_data;
   logic signed [W-1:0]        rd_x, rd_y;
   logic                       mul_en;
   logic signed [OPW-1:0]      mul_a, mul_b;
   logic signed [PW-1:0]       product;
   pipt_pkg::edge_verdict_type verdict;
   logic [CW-1:0]              count_m1;
   logic [AW:0]                idx_inc;
   logic                       idx_last;
   logic signed [OPW-1:0]      dxp, dxq;
   logic                       final_parity, final_bound;

   assign op         = pipt_pkg::op_type'(req_op);
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign imm_accept = accept && !(op == pipt_pkg::OP_TEST && count_ff != '0);
   assign rd_x       = rd_data[2*W-1:W];
   assign rd_y       = rd_data[W-1:0];
   assign count_m1   = count_ff - CW'(1);
   assign idx_inc    = {1'b0, idx_ff} + (AW+1)'(1);
   assign idx_last   = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign dxp        = OPW'(rd_x) - OPW'(cx_ff);
   assign dxq        = OPW'(qx_ff) - OPW'(cx_ff);
   assign final_parity = parity_ff ^ verdict.toggle;
   assign final_bound  = bound_ff | verdict.boundary;

   pipt_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (2 * W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pipt_mul_unit #(
      .OPW (OPW)
   ) u_mul (
      .clock   (clock),
      .en      (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // The product register holds the previous edge's right-hand term while the
   // next edge's first product is being formed.
   pipt_edge_judge #(
      .PW (PW)
   ) u_judge (
      .flags   (flags_ff),
      .num     (num_ff),
      .rhs     (product),
      .verdict (verdict)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      num_in        = num_ff;
      flags_in      = flags_ff;
      parity_in     = parity_ff;
      bound_in      = bound_ff;
      rsp_strobe_in = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      rsp_onb_in    = rsp_onb_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      mul_en        = 1'b0;
      mul_a         = OPW'(rd_y) - OPW'(cy_ff);
      mul_b         = OPW'(qx_ff) - OPW'(rd_x);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_inside_in = 1'b0;
               rsp_onb_in    = 1'b0;
               rsp_status_in = pipt_pkg::STATUS_OK;
               unique case (op)
                  pipt_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  pipt_pkg::OP_APPEND: begin
                     if (count_ff == CW'(MAX_VERTICES)) begin
                        rsp_status_in = pipt_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  pipt_pkg::OP_TEST: begin
                     if (count_ff == '0) begin
                        rsp_status_in = pipt_pkg::STATUS_EMPTY;
                     end else begin
                        // Fetch the last vertex first: it opens the closing edge.
                        rsp_strobe_in = 1'b0;
                        rd_en         = 1'b1;
                        rd_addr       = count_m1[AW-1:0];
                        cx_in         = req_coord_x;
                        cy_in         = req_coord_y;
                        state_in      = ST_PRIME;
                     end
                  end
                  pipt_pkg::OP_NONE: begin
                  end
               endcase
            end
         end
         ST_PRIME: begin
            qx_in     = rd_x;
            qy_in     = rd_y;
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_in    = '0;
            parity_in = 1'b0;
            bound_in  = 1'b0;
            state_in  = ST_EDGE_A;
         end
         ST_EDGE_A: begin
            px_in              = rd_x;
            py_in              = rd_y;
            mul_en             = 1'b1;
            flags_in.straddle  = (rd_y >= cy_ff) != (qy_ff >= cy_ff);
            flags_in.same_side = (!dxp[OPW-1] && dxp != '0 && !dxq[OPW-1] && dxq != '0)
                                 || (dxp[OPW-1] && dxq[OPW-1]);
            flags_in.px_ge     = (rd_x >= cx_ff);
            flags_in.den_pos   = (qy_ff > rd_y);
            // Settle the edge before this one, except on the first edge of a walk.
            if (idx_ff != '0) begin
               parity_in = final_parity;
               bound_in  = final_bound;
            end
            state_in = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            mul_en = 1'b1;
            mul_a  = OPW'(qy_ff) - OPW'(py_ff);
            mul_b  = OPW'(px_ff) - OPW'(cx_ff);
            num_in = product;
            qx_in  = px_ff;
            qy_in  = py_ff;
            if (idx_last) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[AW-1:0];
               idx_in   = idx_inc[AW-1:0];
               state_in = ST_EDGE_A;
            end
         end
         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_inside_in = final_parity && !final_bound;
            rsp_onb_in    = final_bound;
            rsp_status_in = pipt_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff        <= idx_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      num_ff        <= num_in;
      flags_ff      <= flags_in;
      parity_ff     <= parity_in;
      bound_ff      <= bound_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_onb_ff    <= rsp_onb_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_inside_res  = rsp_inside_ff;
   assign rsp_on_boundary = rsp_onb_ff;
   assign rsp_status      = rsp_status_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_DONE) || $past(imm_accept))
      else $error("Result word without a finished walk or an immediate command.");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("Result word shown while a walk is in progress.");

   a_edge_two_pass: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EDGE_A |=> state_ff == ST_EDGE_B)
      else $error("Edge walk skipped its second multiplier pass.");

   a_boundary_not_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_on_boundary |-> !rsp_inside_res && rsp_status == pipt_pkg::STATUS_OK)
      else $error("Boundary result also reports inside or a bad status.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("Vertex count exceeds the store depth.");

endmodule

// ----- tb/point_in_polygon_test_core_tb.sv -----
// Self-checking testbench for the point-in-polygon test core.
`timescale 1ns / 1ps

module point_in_polygon_test_core_tb;

   localparam int POLY_DEPTH = 64;

   typedef struct packed {
      logic                 inside_res;
      logic                 on_boundary;
      pipt_pkg::status_type status;
   } poly_verdict_type;

   typedef struct packed {
      pipt_pkg::op_type     op;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic                 typed;
      logic                 e_inside;
      logic                 e_onb;
      pipt_pkg::status_type e_status;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic signed [15:0] req_coord_x;
   logic signed [15:0] req_coord_y;
   logic               rsp_strobe;
   logic               rsp_inside_res;
   logic               rsp_on_boundary;
   logic [1:0]         rsp_status;

   // Predictor copy of the vertex store.
   logic signed [15:0] vtx_x [POLY_DEPTH];
   logic signed [15:0] vtx_y [POLY_DEPTH];
   int                 vtx_count;

   poly_verdict_type   pending_verdicts [$];
   int                 mismatch_count;
   int                 sender_idle_pct;

   // Rows with typed = 1 carry an expectation that is obvious by inspection.
   directed_row_type directed_rows [25] = '{
      '{pipt_pkg::OP_TEST,   16'sd0,    16'sd0,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_EMPTY},
      '{pipt_pkg::OP_NONE,   16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd0,    16'sd0,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sh7FFF, 16'sd0,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd0,    16'sh7FFF, 1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sh8000, 16'sd0,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_CLEAR,  16'shFFFF, 16'shFFFF, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd1,    16'sd1,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_EMPTY},
      '{pipt_pkg::OP_APPEND, 16'sd0,    16'sd0,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sd10,   16'sd0,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_APPEND, 16'sd0,    16'sd10,   1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd5,    16'sd5,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd2,    16'sd2,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   -16'sd1,   16'sd3,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd20,   16'sd20,   1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_NONE,   16'sd0,    16'sd0,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sd0,    16'sd5,    1'b0, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_CLEAR,  16'sd0,    16'sd0,    1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_OK},
      '{pipt_pkg::OP_TEST,   16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, pipt_pkg::STATUS_EMPTY}
   };

   point_in_polygon_test_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_on_boundary (rsp_on_boundary),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Crossing parity of a horizontal ray from the point against the stored polygon.
   function automatic poly_verdict_type classify_point(input longint cx, input longint cy);
      poly_verdict_type v;
      bit               parity;
      bit               qhigh;
      bit               phigh;
      longint           qx, qy, px, py, dxp, dxq, num, den, rhs;
      v = '{1'b0, 1'b0, pipt_pkg::STATUS_OK};
      parity = 1'b0;
      qx = vtx_x[vtx_count-1];
      qy = vtx_y[vtx_count-1];
      qhigh = (qy >= cy);
      for (int i = 0; i < vtx_count; i++) begin
         px = vtx_x[i];
         py = vtx_y[i];
         phigh = (py >= cy);
         if (phigh != qhigh) begin
            dxp = px - cx;
            dxq = qx - cx;
            if ((dxp > 0 && dxq > 0) || (dxp < 0 && dxq < 0)) begin
               if (px >= cx) parity = !parity;
            end else begin
               // Intercept compare without division: sign of den decides the direction.
               num = (py - cy) * (qx - px);
               den = qy - py;
               rhs = den * dxp;
               if (num == rhs) begin
                  v.on_boundary = 1'b1;
                  return v;
               end
               if (den > 0 ? (num <= rhs) : (num >= rhs)) parity = !parity;
            end
         end
         qx = px;
         qy = py;
         qhigh = phigh;
      end
      v.inside_res = parity;
      return v;
   endfunction

   function automatic poly_verdict_type apply_word(input pipt_pkg::op_type op,
                                                   input logic signed [15:0] x,
                                                   input logic signed [15:0] y);
      poly_verdict_type v;
      v = '{1'b0, 1'b0, pipt_pkg::STATUS_OK};
      case (op)
         pipt_pkg::OP_CLEAR: vtx_count = 0;
         pipt_pkg::OP_APPEND: begin
            if (vtx_count < POLY_DEPTH) begin
               vtx_x[vtx_count] = x;
               vtx_y[vtx_count] = y;
               vtx_count++;
            end else begin
               v.status = pipt_pkg::STATUS_FULL;
            end
         end
         pipt_pkg::OP_TEST: begin
            if (vtx_count == 0) v.status = pipt_pkg::STATUS_EMPTY;
            else v = classify_point(x, y);
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic send_word(input pipt_pkg::op_type op, input logic signed [15:0] x,
                            input logic signed [15:0] y, input bit typed,
                            input poly_verdict_type typed_v);
      poly_verdict_type v;
      if ($urandom_range(0, 99) < sender_idle_pct)
         idle_cycles($urandom_range(0, 4) == 0 ? $urandom_range(1, 150) : $urandom_range(1, 4));
      @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_coord_x = x;
      req_coord_y = y;
      do @(posedge clock); while (busy);
      v = apply_word(op, x, y);
      pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_coord(input int scale);
      logic signed [15:0] c;
      case (scale)
         0: c = 16'(int'($urandom_range(0, 12)) - 6);
         1: c = 16'(int'($urandom_range(0, 600)) - 300);
         2: c = 16'($urandom);
         default: begin
            case ($urandom_range(0, 5))
               0: c = 16'sh8000;
               1: c = 16'sh8001;
               2: c = 16'shFFFF;
               3: c = 16'sd0;
               4: c = 16'sh7FFE;
               default: c = 16'sh7FFF;
            endcase
         end
      endcase
      return c;
   endfunction

   // Mostly whole polygons with random content followed by test words; the rest is noise.
   task automatic run_phase(input int budget);
      int                 sent;
      int                 scale;
      int                 n_vtx;
      int                 pick;
      int                 a, b;
      bit                 first;
      pipt_pkg::op_type   op;
      logic signed [15:0] tx, ty;
      logic signed [16:0] sx, sy;
      sent = 0;
      first = 1'b1;
      while (sent < budget) begin
         if (first || $urandom_range(0, 99) < 75) begin
            scale = $urandom_range(0, 3);
            if (first || $urandom_range(0, 7) != 0) begin
               send_word(pipt_pkg::OP_CLEAR, pick_coord(2), pick_coord(2), 1'b0, '0);
               sent++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) n_vtx = 0;
            else if (pick < 8) n_vtx = $urandom_range(1, 2);
            else if (pick < 18) n_vtx = $urandom_range(62, 68);
            else n_vtx = $urandom_range(3, 10);
            // Start each phase by overrunning the store so refusals always occur.
            if (first) n_vtx = POLY_DEPTH + 2;
            repeat (n_vtx) begin
               send_word(pipt_pkg::OP_APPEND, pick_coord(scale), pick_coord(scale), 1'b0, '0);
               sent++;
            end
            repeat ($urandom_range(1, 6)) begin
               a = (vtx_count > 0) ? $urandom_range(0, vtx_count - 1) : 0;
               b = (vtx_count > 0) ? $urandom_range(0, vtx_count - 1) : 0;
               case ((vtx_count > 0) ? $urandom_range(0, 2) : 2)
                  0: begin
                     tx = vtx_x[a];
                     ty = vtx_y[a];
                  end
                  1: begin
                     sx = vtx_x[a] + vtx_x[b];
                     sy = vtx_y[a] + vtx_y[b];
                     tx = sx[16:1];
                     ty = sy[16:1];
                  end
                  default: begin
                     tx = pick_coord(scale);
                     ty = pick_coord(scale);
                  end
               endcase
               send_word(pipt_pkg::OP_TEST, tx, ty, 1'b0, '0);
               sent++;
            end
            first = 1'b0;
         end else begin
            op = pipt_pkg::op_type'($urandom_range(0, 3));
            send_word(op, pick_coord(2), pick_coord(2), 1'b0, '0);
            if (op != pipt_pkg::OP_NONE) sent++;
         end
         if ($urandom_range(0, 9) == 0) drain_results();
      end
   endtask

   always @(posedge clock) begin : result_check
      poly_verdict_type want;
      if (!reset && rsp_strobe) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result word: inside_res %0b on_boundary %0b status %0d",
                     $time, rsp_inside_res, rsp_on_boundary, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_inside_res !== want.inside_res) begin
               $display("%0t: inside_res mismatch: expected %0b actual %0b",
                        $time, want.inside_res, rsp_inside_res);
               mismatch_count++;
            end
            if (rsp_on_boundary !== want.on_boundary) begin
               $display("%0t: on_boundary mismatch: expected %0b actual %0b",
                        $time, want.on_boundary, rsp_on_boundary);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = pipt_pkg::OP_CLEAR;
      req_coord_x = '0;
      req_coord_y = '0;
      vtx_count = 0;
      mismatch_count = 0;
      sender_idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].typed,
                   '{directed_rows[i].e_inside, directed_rows[i].e_onb,
                     directed_rows[i].e_status});
      drain_results();

      sender_idle_pct = 21;
      run_phase(460);
      drain_results();
      sender_idle_pct = 45;
      run_phase(460);
      drain_results();
      sender_idle_pct = 0;
      run_phase(480);
      drain_results();

      // Watch well past the end of a full 64-vertex test word.
      repeat (300) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
sv/pipt_pkg.sv
sv/pipt_vertex_ram.sv
sv/pipt_mul_unit.sv
sv/pipt_edge_judge.sv
sv/point_in_polygon_test_core.sv
tb/point_in_polygon_test_core_tb.sv
